### rtl/core/mcpr_pkg.sv
package mcpr_pkg;

    localparam int NODE_W       = 10;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int FRAC_W       = 16;
    localparam int VISIT_W      = 32;
    localparam int NODE_TOTAL_W = 11;
    localparam int STEPS_W      = 20;
    localparam int WALKS_W      = 24;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 24;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD_EDGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WALK_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_COUNT = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_TOTAL = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEPS      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALK_TOTAL = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING    = 4'd3;

    // Configuration reset values.
    localparam logic [NODE_TOTAL_W-1:0] NODE_TOTAL_RST = 11'd1;
    localparam logic [STEPS_W-1:0]      STEPS_RST      = 20'd1000;
    localparam logic [WALKS_W-1:0]      WALK_TOTAL_RST = 24'd100000;
    localparam logic [FRAC_W-1:0]       DAMPING_RST    = 16'd55706;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
        logic [FRAC_W-1:0] coin;
        logic [FRAC_W-1:0] pick;
        logic [NODE_W-1:0] jump_node;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   visited_node;
        logic [VISIT_W-1:0]  visit_total;
        logic                walk_ended;
    } out_item_t;

endpackage

### rtl/core/mcpr_store.sv
module mcpr_store #(
    parameter int NODE_DEPTH  = 1024,
    parameter int DEG_W       = 5,
    parameter int COUNT_BITS  = 32,
    parameter int CHILD_DEPTH = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    output logic                             busy,
    input  logic [$clog2(NODE_DEPTH)-1:0]    node_rd_addr,
    output logic [DEG_W-1:0]                 node_rd_degree,
    output logic [COUNT_BITS-1:0]            node_rd_count,
    input  logic                             node_wr_en,
    input  logic [$clog2(NODE_DEPTH)-1:0]    node_wr_addr,
    input  logic [DEG_W-1:0]                 node_wr_degree,
    input  logic [COUNT_BITS-1:0]            node_wr_count,
    input  logic [$clog2(CHILD_DEPTH)-1:0]   child_rd_addr,
    output logic [mcpr_pkg::NODE_W-1:0]      child_rd_data,
    input  logic                             child_wr_en,
    input  logic [$clog2(CHILD_DEPTH)-1:0]   child_wr_addr,
    input  logic [mcpr_pkg::NODE_W-1:0]      child_wr_data
);

    localparam int NODE_AW = $clog2(NODE_DEPTH);
    localparam int WORD_W  = DEG_W + COUNT_BITS;

    // Each node word holds its degree above its visit count.
    logic [WORD_W-1:0]               node_mem [NODE_DEPTH];
    logic [mcpr_pkg::NODE_W-1:0]     child_mem [CHILD_DEPTH];
    logic [WORD_W-1:0]               node_rd_reg;

    logic [NODE_AW-1:0] clr_reg;
    logic               busy_reg;

    logic               nwe;
    logic [NODE_AW-1:0] nwa;
    logic [WORD_W-1:0]  nwd;

    // The clearing sweep owns the node write port until every word is zero.
    always_comb
    begin
        nwe = busy_reg || node_wr_en;
        nwa = busy_reg ? clr_reg : node_wr_addr;
        nwd = busy_reg ? '0 : {node_wr_degree, node_wr_count};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_reg == NODE_AW'(NODE_DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nwe)
        begin
            node_mem[nwa] <= nwd;
        end
        node_rd_reg <= node_mem[node_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (child_wr_en)
        begin
            child_mem[child_wr_addr] <= child_wr_data;
        end
        child_rd_data <= child_mem[child_rd_addr];
    end

    assign busy           = busy_reg;
    assign node_rd_degree = node_rd_reg[WORD_W-1 -: DEG_W];
    assign node_rd_count  = node_rd_reg[COUNT_BITS-1:0];

endmodule

### rtl/core/monte_carlo_pagerank_walker_unit.sv
// Channel  Direction  Handshake            Carries
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
// in       in         in_valid/in_ready    in_item (one request)
// out      out        out_valid/out_ready  out_item (one result per request)
//
// A request that is rejected at once is answered from S_IDLE; load_edge, read_count
// and a walk step that teleports finish in S_NODE; a walk step that moves to a child
// also passes through S_CHILD, since the degree read and count write-back on the
// node memory are chained with the child slot read on the child memory.
// After reset, a clearing pass zeroes all min(MAX_NODES, 1024) words of the node
// memory; requests wait during it while configuration writes are taken.
// A finished result waits in the output register; the next request is still
// taken, and only its own result stalls while the output is full.
module monte_carlo_pagerank_walker_unit #(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_DEGREE = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mcpr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mcpr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  mcpr_pkg::in_item_t                    in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output mcpr_pkg::out_item_t                   out_item
);

    localparam int NODE_W      = mcpr_pkg::NODE_W;
    localparam int NODE_DEPTH  = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
    localparam int CHILD_DEPTH = NODE_DEPTH * MAX_DEGREE;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int PROD_W      = mcpr_pkg::FRAC_W + DEG_W;

    typedef enum logic [1:0] {S_IDLE, S_NODE, S_CHILD, S_WAIT} state_t;

    state_t                               state_reg, state_next;
    logic [NODE_W-1:0]                    cur_reg, cur_next;
    logic [mcpr_pkg::STEPS_W-1:0]         step_reg, step_next;
    logic [mcpr_pkg::WALKS_W-1:0]         walks_done_reg, walks_done_next;
    logic                                 out_valid_reg, out_valid_next;
    mcpr_pkg::out_item_t                  out_reg, out_next;
    mcpr_pkg::out_item_t                  res_reg, res_next;

    logic [mcpr_pkg::NODE_TOTAL_W-1:0]    node_total_reg;
    logic [mcpr_pkg::STEPS_W-1:0]         steps_reg;
    logic [mcpr_pkg::WALKS_W-1:0]         walk_total_reg;
    logic [mcpr_pkg::FRAC_W-1:0]          damping_reg;

    logic [mcpr_pkg::OP_W-1:0]            op_reg;
    logic [NODE_W-1:0]                    node_reg;
    logic [NODE_W-1:0]                    dst_reg;
    logic [mcpr_pkg::FRAC_W-1:0]          coin_reg;
    logic [mcpr_pkg::FRAC_W-1:0]          pick_reg;
    logic [NODE_W-1:0]                    jump_reg;

    logic                                 store_busy;
    logic [NODE_AW-1:0]                   node_rd_addr;
    logic [DEG_W-1:0]                     deg;
    logic [COUNT_BITS-1:0]                cnt;
    logic                                 node_wr_en;
    logic [DEG_W-1:0]                     node_wr_degree;
    logic [COUNT_BITS-1:0]                node_wr_count;
    logic [CHILD_AW-1:0]                  child_addr;
    logic [NODE_W-1:0]                    child_rd_data;
    logic                                 child_wr_en;

    logic                                 accept;
    logic [NODE_W-1:0]                    walk_node;
    logic [NODE_AW-1:0]                   node_idx;
    logic [COUNT_BITS-1:0]                cnt_inc;
    logic                                 move;
    logic [PROD_W-1:0]                    prod;
    logic [DEG_W-1:0]                     slot;
    logic [mcpr_pkg::STEPS_W-1:0]         step_inc;
    logic                                 walk_end;
    logic                                 fire;
    mcpr_pkg::out_item_t                  res;

    function automatic logic node_ok(input logic [NODE_W-1:0] n,
                                     input logic [mcpr_pkg::NODE_TOTAL_W-1:0] total);
        logic [mcpr_pkg::NODE_TOTAL_W-1:0] nx;
        nx = {1'b0, n};
        return (nx < total) && (nx < mcpr_pkg::NODE_TOTAL_W'(NODE_DEPTH));
    endfunction

    mcpr_store #(
        .NODE_DEPTH  (NODE_DEPTH),
        .DEG_W       (DEG_W),
        .COUNT_BITS  (COUNT_BITS),
        .CHILD_DEPTH (CHILD_DEPTH)
    ) u_store (
        .clk            (clk),
        .rst_n          (rst_n),
        .busy           (store_busy),
        .node_rd_addr   (node_rd_addr),
        .node_rd_degree (deg),
        .node_rd_count  (cnt),
        .node_wr_en     (node_wr_en),
        .node_wr_addr   (node_idx),
        .node_wr_degree (node_wr_degree),
        .node_wr_count  (node_wr_count),
        .child_rd_addr  (child_addr),
        .child_rd_data  (child_rd_data),
        .child_wr_en    (child_wr_en),
        .child_wr_addr  (child_addr),
        .child_wr_data  (dst_reg)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !store_busy;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // A step with no walk in progress starts the new walk at jump_node.
    assign walk_node    = (step_reg == '0) ? in_item.jump_node : cur_reg;
    assign node_rd_addr = NODE_AW'((in_item.operation == mcpr_pkg::OP_WALK_STEP) ?
                                   walk_node : in_item.source_node);

    always_comb
    begin
        node_idx = NODE_AW'(node_reg);
        cnt_inc  = (cnt == '1) ? cnt : cnt + 1'b1;
        move     = (coin_reg < damping_reg) && (deg != '0);
        prod     = PROD_W'(pick_reg) * PROD_W'(deg);
        slot     = (op_reg == mcpr_pkg::OP_LOAD_EDGE) ? deg : prod[mcpr_pkg::FRAC_W +: DEG_W];
        child_addr = CHILD_AW'(node_idx) * CHILD_AW'(MAX_DEGREE) + CHILD_AW'(slot);
        step_inc = step_reg + 1'b1;
        walk_end = step_inc >= steps_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        walks_done_next = walks_done_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        node_wr_en      = 1'b0;
        node_wr_degree  = deg;
        node_wr_count   = cnt;
        child_wr_en     = 1'b0;
        fire            = 1'b0;
        res             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.operation)
                        mcpr_pkg::OP_LOAD_EDGE:
                        begin
                            if (!node_ok(in_item.source_node, node_total_reg) ||
                                !node_ok(in_item.target_node, node_total_reg))
                            begin
                                fire       = 1'b1;
                                res.status = mcpr_pkg::ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_NODE;
                            end
                        end
                        mcpr_pkg::OP_WALK_STEP:
                        begin
                            if (walks_done_reg >= walk_total_reg)
                            begin
                                fire       = 1'b1;
                                res.status = mcpr_pkg::ST_FINISHED;
                            end
                            else if (!node_ok(walk_node, node_total_reg))
                            begin
                                // The walk in progress is dropped without being counted.
                                fire             = 1'b1;
                                res.status       = mcpr_pkg::ST_RANGE;
                                res.visited_node = walk_node;
                                step_next        = '0;
                            end
                            else
                            begin
                                state_next = S_NODE;
                            end
                        end
                        mcpr_pkg::OP_READ_COUNT:
                        begin
                            if (!node_ok(in_item.source_node, node_total_reg))
                            begin
                                fire             = 1'b1;
                                res.status       = mcpr_pkg::ST_RANGE;
                                res.visited_node = in_item.source_node;
                            end
                            else
                            begin
                                state_next = S_NODE;
                            end
                        end
                        default:
                        begin
                            fire       = 1'b1;
                            res.status = mcpr_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_NODE:
            begin
                case (op_reg)
                    mcpr_pkg::OP_LOAD_EDGE:
                    begin
                        fire = 1'b1;
                        if (deg >= DEG_W'(MAX_DEGREE))
                        begin
                            res.status = mcpr_pkg::ST_DROPPED;
                        end
                        else
                        begin
                            node_wr_en     = 1'b1;
                            node_wr_degree = deg + 1'b1;
                            child_wr_en    = 1'b1;
                            res.status     = mcpr_pkg::ST_OK;
                        end
                    end
                    mcpr_pkg::OP_READ_COUNT:
                    begin
                        fire             = 1'b1;
                        res.status       = mcpr_pkg::ST_OK;
                        res.visited_node = node_reg;
                        res.visit_total  = mcpr_pkg::VISIT_W'(64'(cnt));
                    end
                    mcpr_pkg::OP_WALK_STEP:
                    begin
                        node_wr_en       = 1'b1;
                        node_wr_count    = cnt_inc;
                        res.status       = mcpr_pkg::ST_OK;
                        res.visited_node = node_reg;
                        res.visit_total  = mcpr_pkg::VISIT_W'(64'(cnt_inc));
                        res.walk_ended   = walk_end;
                        step_next        = walk_end ? '0 : step_inc;
                        if (walk_end)
                        begin
                            walks_done_next = walks_done_reg + 1'b1;
                        end
                        if (move)
                        begin
                            // The result is ready; only the next node waits on the child read.
                            res_next   = res;
                            state_next = S_CHILD;
                        end
                        else
                        begin
                            fire     = 1'b1;
                            cur_next = jump_reg;
                        end
                    end
                    default:
                    begin
                        fire       = 1'b1;
                        res.status = mcpr_pkg::ST_RANGE;
                    end
                endcase
            end
            S_CHILD:
            begin
                cur_next = child_rd_data;
                fire     = 1'b1;
                res      = res_reg;
            end
            S_WAIT:
            begin
                fire = 1'b1;
                res  = res_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fire)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = res;
                state_next = S_WAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            step_reg       <= '0;
            walks_done_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            step_reg       <= step_next;
            walks_done_reg <= walks_done_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_item.operation;
            node_reg <= (in_item.operation == mcpr_pkg::OP_WALK_STEP) ?
                        walk_node : in_item.source_node;
            dst_reg  <= in_item.target_node;
            coin_reg <= in_item.coin;
            pick_reg <= in_item.pick;
            jump_reg <= in_item.jump_node;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_total_reg <= mcpr_pkg::NODE_TOTAL_RST;
            steps_reg      <= mcpr_pkg::STEPS_RST;
            walk_total_reg <= mcpr_pkg::WALK_TOTAL_RST;
            damping_reg    <= mcpr_pkg::DAMPING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mcpr_pkg::CFG_NODE_TOTAL:
                begin
                    node_total_reg <= cfg_data[mcpr_pkg::NODE_TOTAL_W-1:0];
                end
                mcpr_pkg::CFG_STEPS:
                begin
                    steps_reg <= cfg_data[mcpr_pkg::STEPS_W-1:0];
                end
                mcpr_pkg::CFG_WALK_TOTAL:
                begin
                    walk_total_reg <= cfg_data[mcpr_pkg::WALKS_W-1:0];
                end
                mcpr_pkg::CFG_DAMPING:
                begin
                    damping_reg <= cfg_data[mcpr_pkg::FRAC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The clearing pass only runs before any request has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> (state_reg == S_IDLE) && !out_valid_reg)
        else $error("request activity during the node memory clearing pass");

    // The child slot is read only right after the node word was read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHILD) |-> ($past(state_reg) == S_NODE))
        else $error("child read without a preceding node read");

    // The walk counter moves only at the node stage of a walk step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (walks_done_reg != $past(walks_done_reg)) |->
            ($past(state_reg) == S_NODE) && ($past(op_reg) == mcpr_pkg::OP_WALK_STEP))
        else $error("walk count changed outside a walk step");

endmodule

### verif/monte_carlo_pagerank_walker_unit_test.sv
module monte_carlo_pagerank_walker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_CAP   = 1024;
    localparam int DEGREE_CAP = 16;
    localparam logic [mcpr_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mcpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mcpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    mcpr_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    mcpr_pkg::out_item_t out_item;

    monte_carlo_pagerank_walker_unit #(
        .MAX_NODES  (NODE_CAP),
        .MAX_DEGREE (DEGREE_CAP),
        .COUNT_BITS (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Register copies, as written through the configuration port.
    logic [mcpr_pkg::NODE_TOTAL_W-1:0] cfg_nodes = mcpr_pkg::NODE_TOTAL_RST;
    logic [mcpr_pkg::STEPS_W-1:0]      cfg_steps = mcpr_pkg::STEPS_RST;
    logic [mcpr_pkg::WALKS_W-1:0]      cfg_walks = mcpr_pkg::WALK_TOTAL_RST;
    logic [mcpr_pkg::FRAC_W-1:0]       cfg_damp  = mcpr_pkg::DAMPING_RST;

    // Graph and walk state as the block should hold it.
    logic [4:0]                   degree   [NODE_CAP];
    logic [mcpr_pkg::NODE_W-1:0]  children [NODE_CAP][DEGREE_CAP];
    logic [mcpr_pkg::VISIT_W-1:0] visits   [NODE_CAP];
    logic [mcpr_pkg::NODE_W-1:0]  walk_node = '0;
    int unsigned                  step_pos = 0;
    logic [mcpr_pkg::WALKS_W-1:0] walks_done = '0;

    mcpr_pkg::in_item_t  request_q [$];
    mcpr_pkg::out_item_t outcome_q [$];

    bit req_taken = 1'b0;
    bit quiet = 1'b0;
    bit long_hold_armed = 1'b1;
    int send_gap = 0;
    int hold_left = 0;
    int results_seen = 0;
    int fails = 0;
    int hot_span = 1;

    function automatic bit node_valid(input logic [mcpr_pkg::NODE_W-1:0] n);
        return ({1'b0, n} < cfg_nodes) && (int'(n) < NODE_CAP);
    endfunction

    function automatic mcpr_pkg::out_item_t walker_outcome(input mcpr_pkg::in_item_t req);
        mcpr_pkg::out_item_t res;
        logic [mcpr_pkg::NODE_W-1:0] node;
        logic [4:0] deg;
        int unsigned slot;
        res = '0;
        case (req.operation)
            mcpr_pkg::OP_LOAD_EDGE:
            begin
                if (!node_valid(req.source_node) || !node_valid(req.target_node))
                    res.status = mcpr_pkg::ST_RANGE;
                else if (degree[req.source_node] >= DEGREE_CAP)
                    res.status = mcpr_pkg::ST_DROPPED;
                else
                begin
                    children[req.source_node][degree[req.source_node]] = req.target_node;
                    degree[req.source_node] = degree[req.source_node] + 1'b1;
                end
            end
            mcpr_pkg::OP_WALK_STEP:
            begin
                if (walks_done >= cfg_walks)
                    res.status = mcpr_pkg::ST_FINISHED;
                else
                begin
                    node = (step_pos == 0) ? req.jump_node : walk_node;
                    res.visited_node = node;
                    if (!node_valid(node))
                    begin
                        // The walk is dropped without counting; the next step restarts.
                        res.status = mcpr_pkg::ST_RANGE;
                        step_pos = 0;
                    end
                    else
                    begin
                        deg = degree[node];
                        if (visits[node] != '1)
                            visits[node] = visits[node] + 1'b1;
                        res.visit_total = visits[node];
                        if (req.coin < cfg_damp && deg != 0)
                        begin
                            slot = (32'(req.pick) * 32'(deg)) >> 16;
                            walk_node = children[node][slot];
                        end
                        else
                            walk_node = req.jump_node;
                        step_pos++;
                        if (step_pos >= cfg_steps)
                        begin
                            step_pos = 0;
                            walks_done = walks_done + 1'b1;
                            res.walk_ended = 1'b1;
                        end
                    end
                end
            end
            mcpr_pkg::OP_READ_COUNT:
            begin
                res.visited_node = req.source_node;
                if (node_valid(req.source_node))
                    res.visit_total = visits[req.source_node];
                else
                    res.status = mcpr_pkg::ST_RANGE;
            end
            default:
                res.status = mcpr_pkg::ST_RANGE;
        endcase
        return res;
    endfunction

    function automatic logic [mcpr_pkg::NODE_W-1:0] random_node();
        int unsigned r;
        int unsigned span;
        r = $urandom_range(0, 99);
        span = (cfg_nodes > NODE_CAP) ? NODE_CAP : cfg_nodes;
        if (r < 85)
            return mcpr_pkg::NODE_W'($urandom_range(0, hot_span - 1));
        if (r < 93)
            return mcpr_pkg::NODE_W'($urandom_range(0, span - 1));
        return mcpr_pkg::NODE_W'($urandom_range(0, NODE_CAP - 1));
    endfunction

    function automatic mcpr_pkg::in_item_t random_request();
        mcpr_pkg::in_item_t req;
        int unsigned r;
        r = $urandom_range(0, 99);
        req.coin        = mcpr_pkg::FRAC_W'($urandom());
        req.pick        = mcpr_pkg::FRAC_W'($urandom());
        req.source_node = random_node();
        req.target_node = random_node();
        req.jump_node   = random_node();
        if (r < 22)
            req.operation = mcpr_pkg::OP_LOAD_EDGE;
        else if (r < 82)
            req.operation = mcpr_pkg::OP_WALK_STEP;
        else if (r < 95)
            req.operation = mcpr_pkg::OP_READ_COUNT;
        else
        begin
            req = mcpr_pkg::in_item_t'({$urandom(), $urandom()});
            req.operation = OP_RESERVED;
        end
        return req;
    endfunction

    task automatic enqueue_op(input logic [mcpr_pkg::OP_W-1:0] op, input int src,
                              input int dst, input int coin, input int pick,
                              input int jump);
        mcpr_pkg::in_item_t req;
        req.operation   = op;
        req.source_node = mcpr_pkg::NODE_W'(src);
        req.target_node = mcpr_pkg::NODE_W'(dst);
        req.coin        = mcpr_pkg::FRAC_W'(coin);
        req.pick        = mcpr_pkg::FRAC_W'(pick);
        req.jump_node   = mcpr_pkg::NODE_W'(jump);
        request_q = {request_q, req};
    endtask

    task automatic write_reg(input logic [mcpr_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= mcpr_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            mcpr_pkg::CFG_NODE_TOTAL: cfg_nodes = mcpr_pkg::NODE_TOTAL_W'(value);
            mcpr_pkg::CFG_STEPS:      cfg_steps = mcpr_pkg::STEPS_W'(value);
            mcpr_pkg::CFG_WALK_TOTAL: cfg_walks = mcpr_pkg::WALKS_W'(value);
            mcpr_pkg::CFG_DAMPING:    cfg_damp  = mcpr_pkg::FRAC_W'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The check runs just after the falling edge, once the driver's update has landed.
    task automatic drain();
        @(negedge clk);
        #1;
        while (request_q.size() != 0 || in_valid || outcome_q.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
        repeat (4) @(negedge clk);
    endtask

    // Request side: a new request goes out only once the previous one was taken.
    always @(negedge clk)
    begin : send_requests
        if (rst_n && !(in_valid && !req_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                in_item  <= request_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side stalls, including one long hold-off that backs the block up.
    always @(negedge clk)
    begin : accept_results
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && long_hold_armed && results_seen >= 60)
        begin
            long_hold_armed = 1'b0;
            hold_left = 79;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watch_channels
        mcpr_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    fails++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        fails++;
                    end
                    if (out_item.visited_node !== want.visited_node)
                    begin
                        $error("visited_node: expected %0d, got %0d",
                               want.visited_node, out_item.visited_node);
                        fails++;
                    end
                    if (out_item.visit_total !== want.visit_total)
                    begin
                        $error("visit_total: expected %0d, got %0d",
                               want.visit_total, out_item.visit_total);
                        fails++;
                    end
                    if (out_item.walk_ended !== want.walk_ended)
                    begin
                        $error("walk_ended: expected %0d, got %0d",
                               want.walk_ended, out_item.walk_ended);
                        fails++;
                    end
                end
            end
            req_taken = in_valid && in_ready;
            if (req_taken)
                outcome_q = {outcome_q, walker_outcome(in_item)};
        end
    end

    initial
    begin
        int unsigned n_val;
        int unsigned s_val;
        int unsigned w_val;
        int unsigned d_val;
        int count;
        foreach (degree[i])
        begin
            degree[i] = '0;
            visits[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a single node, so every other index is out of range.
        enqueue_op(OP_RESERVED, 1023, 1023, 65535, 65535, 1023);
        enqueue_op(mcpr_pkg::OP_LOAD_EDGE, 0, 0, 0, 0, 0);
        enqueue_op(mcpr_pkg::OP_LOAD_EDGE, 0, 1, 0, 0, 0);
        enqueue_op(mcpr_pkg::OP_WALK_STEP, 0, 0, 0, 65535, 0);
        enqueue_op(mcpr_pkg::OP_WALK_STEP, 0, 0, 65535, 0, 1023);
        enqueue_op(mcpr_pkg::OP_WALK_STEP, 0, 0, 0, 0, 0);
        drain();

        // One-step walks, only two of them allowed, and a full adjacency list.
        write_reg(mcpr_pkg::CFG_NODE_TOTAL, NODE_CAP);
        write_reg(mcpr_pkg::CFG_STEPS, 1);
        write_reg(mcpr_pkg::CFG_WALK_TOTAL, walks_done + 2);
        write_reg(mcpr_pkg::CFG_DAMPING, 65535);
        @(posedge clk);
        for (int k = 0; k <= DEGREE_CAP; k++)
            enqueue_op(mcpr_pkg::OP_LOAD_EDGE, 5, 6 + k, 0, 0, 0);
        enqueue_op(mcpr_pkg::OP_WALK_STEP, 0, 0, 0, 65535, 5);
        enqueue_op(mcpr_pkg::OP_WALK_STEP, 0, 0, 0, 0, 5);
        enqueue_op(mcpr_pkg::OP_WALK_STEP, 0, 0, 0, 0, 5);
        enqueue_op(mcpr_pkg::OP_READ_COUNT, 5, 0, 0, 0, 0);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            count = 110;
            case (p)
                0:
                begin
                    n_val = NODE_CAP;
                    s_val = $urandom_range(1, 8);
                    w_val = 24'hFFFFFF;
                    d_val = $urandom_range(30000, 65535);
                end
                1:
                begin
                    n_val = $urandom_range(2, 64);
                    s_val = 20'hFFFFF;
                    w_val = 24'hFFFFFF;
                    d_val = 65535;
                end
                2:
                begin
                    // Zero steps per walk ends every walk at once; three walks remain.
                    n_val = 1;
                    s_val = 0;
                    w_val = walks_done + 3;
                    d_val = 0;
                    count = 60;
                end
                3:
                begin
                    n_val = $urandom_range(8, 40);
                    s_val = $urandom_range(2, 6);
                    w_val = 0;
                    d_val = $urandom_range(0, 65535);
                    count = 60;
                end
                default:
                begin
                    n_val = $urandom_range(16, NODE_CAP);
                    s_val = $urandom_range(1, 10);
                    w_val = 24'hFFFFFF;
                    d_val = $urandom_range(0, 65535);
                    count = 160;
                end
            endcase
            write_reg(mcpr_pkg::CFG_NODE_TOTAL, n_val);
            write_reg(mcpr_pkg::CFG_STEPS, s_val);
            write_reg(mcpr_pkg::CFG_WALK_TOTAL, w_val);
            write_reg(mcpr_pkg::CFG_DAMPING, d_val);
            @(posedge clk);
            hot_span = (n_val < 24) ? n_val : 24;
            if (p == 4)
                quiet = 1'b1;
            for (int k = 0; k < count; k++)
                request_q = {request_q, random_request()};
            drain();
        end

        repeat (8) @(negedge clk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("FAIL");
        $finish;
    end

endmodule
